@@ src/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, constants and helpers of the Art-Net packet parser.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int MAX_SLOTS    = 512;
  localparam int MAX_DATAGRAM = 1024;

  // byte position counts up to MAX_DATAGRAM inclusive
  localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

  // byte offsets inside the datagram
  localparam int POS_OPCODE_LO  = 8;
  localparam int POS_OPCODE_HI  = 9;
  localparam int POS_VERSION_HI = 10;
  localparam int POS_VERSION_LO = 11;
  localparam int POS_SEQUENCE   = 12;
  localparam int POS_PHYSICAL   = 13;
  localparam int POS_PORT_LO    = 14;
  localparam int POS_PORT_HI    = 15;
  localparam int POS_LENGTH_HI  = 16;
  localparam int POS_LENGTH_LO  = 17;

  // minimum sizes
  localparam int MIN_ANY  = 10;
  localparam int MIN_POLL = 14;
  localparam int MIN_DMX  = 18;
  localparam int MIN_LEN  = 2;

  localparam logic [15:0] OP_POLL    = 16'h2000;
  localparam logic [15:0] OP_DMX     = 16'h5000;
  localparam logic [15:0] PORT_LIMIT = 16'h7FFF;

  localparam logic [15:0] MIN_VER_RESET = 16'd14;

  // result kinds
  localparam logic [2:0] KIND_SLOT      = 3'd0;
  localparam logic [2:0] KIND_DONE      = 3'd1;
  localparam logic [2:0] KIND_POLL      = 3'd2;
  localparam logic [2:0] KIND_MALFORMED = 3'd3;
  localparam logic [2:0] KIND_IGNORED   = 3'd4;

  // configuration register indexes
  localparam logic REG_PORT_ADDRESS = 1'b0;
  localparam logic REG_MIN_VERSION  = 1'b1;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [14:0] port_address;
    logic [15:0] min_version;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic [7:0]  frame_sequence;
    logic [7:0]  physical_port;
    logic [9:0]  frame_length;
    logic [31:0] malformed_total;
    logic [31:0] frame_total;
    logic        last_of_run;
  } res_t;

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ src/art_cfg.sv @@
// ----------------------------------------------------------------------------
// art_cfg
// APB-style configuration registers: port address and minimum version.
// ----------------------------------------------------------------------------
module art_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output art_pkg::cfg_t cfg
);

  logic [14:0] port_r;
  logic [15:0] minver_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r   <= '0;
      minver_r <= art_pkg::MIN_VER_RESET;
    end else if (wr_en) begin
      if (reg_sel == art_pkg::REG_PORT_ADDRESS) begin
        port_r <= pwdata[14:0];
      end else begin
        minver_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == art_pkg::REG_PORT_ADDRESS) begin
      prdata = {17'd0, port_r};
    end else begin
      prdata = {16'd0, minver_r};
    end
  end

  assign cfg.port_address = port_r;
  assign cfg.min_version  = minver_r;

endmodule

@@ src/art_parse.sv @@
// ----------------------------------------------------------------------------
// art_parse
// Per-byte header capture, slot streaming and end-of-datagram verdict.
// ----------------------------------------------------------------------------
module art_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  art_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          end_of_datagram,
  output logic [1:0]    push_n,
  output art_pkg::res_t res_a,
  output art_pkg::res_t res_b
);

  localparam int PW = art_pkg::POS_W;
  localparam logic [PW-1:0] POS_MAX   = PW'(art_pkg::MAX_DATAGRAM);
  localparam logic [PW-1:0] POS_SLOT0 = PW'(art_pkg::MIN_DMX);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          id_ok_r, id_ok_nxt;
  logic [15:0]   opcode_r, opcode_nxt;
  logic [15:0]   version_r, version_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    phys_r, phys_nxt;
  logic [15:0]   port_r, port_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [31:0]   mal_r, mal_nxt;
  logic [31:0]   frm_r, frm_nxt;

  logic          capture;
  logic [PW-1:0] slot;
  logic          hdr_good_cur;
  logic          hdr_good_fin;
  logic          slot_emit;
  logic [PW-1:0] size;
  logic [16:0]   need_size;
  logic [2:0]    kind;
  art_pkg::res_t res_slot;
  art_pkg::res_t res_fin;

  assign capture = pos_r < POS_MAX;
  assign slot    = pos_r - POS_SLOT0;

  // capture header fields
  always_comb begin
    id_ok_nxt   = id_ok_r;
    opcode_nxt  = opcode_r;
    version_nxt = version_r;
    seq_nxt     = seq_r;
    phys_nxt    = phys_r;
    port_nxt    = port_r;
    len_nxt     = len_r;
    if (capture) begin
      if (pos_r < PW'(art_pkg::POS_OPCODE_LO)) begin
        if (data_byte != art_pkg::id_byte(pos_r[2:0])) id_ok_nxt = 1'b0;
      end else if (pos_r == PW'(art_pkg::POS_OPCODE_LO)) begin
        opcode_nxt = {8'd0, data_byte};
      end else if (pos_r == PW'(art_pkg::POS_OPCODE_HI)) begin
        opcode_nxt = {data_byte, opcode_r[7:0]};
      end else if (pos_r == PW'(art_pkg::POS_VERSION_HI)) begin
        version_nxt = {data_byte, 8'd0};
      end else if (pos_r == PW'(art_pkg::POS_VERSION_LO)) begin
        version_nxt = {version_r[15:8], data_byte};
      end else if (pos_r == PW'(art_pkg::POS_SEQUENCE)) begin
        seq_nxt = data_byte;
      end else if (pos_r == PW'(art_pkg::POS_PHYSICAL)) begin
        phys_nxt = data_byte;
      end else if (pos_r == PW'(art_pkg::POS_PORT_LO)) begin
        port_nxt = {8'd0, data_byte};
      end else if (pos_r == PW'(art_pkg::POS_PORT_HI)) begin
        port_nxt = {data_byte, port_r[7:0]};
      end else if (pos_r == PW'(art_pkg::POS_LENGTH_HI)) begin
        len_nxt = {data_byte, 8'd0};
      end else if (pos_r == PW'(art_pkg::POS_LENGTH_LO)) begin
        len_nxt = {len_r[15:8], data_byte};
      end
    end
  end

  assign hdr_good_cur = (version_r >= cfg.min_version) &&
                        (len_r >= 16'(art_pkg::MIN_LEN)) &&
                        (len_r <= 16'(art_pkg::MAX_SLOTS)) && !len_r[0] &&
                        (port_r <= art_pkg::PORT_LIMIT);

  assign hdr_good_fin = (version_nxt >= cfg.min_version) &&
                        (len_nxt >= 16'(art_pkg::MIN_LEN)) &&
                        (len_nxt <= 16'(art_pkg::MAX_SLOTS)) && !len_nxt[0] &&
                        (port_nxt <= art_pkg::PORT_LIMIT);

  assign slot_emit = capture && (pos_r >= POS_SLOT0) && id_ok_r &&
                     (opcode_r == art_pkg::OP_DMX) && hdr_good_cur &&
                     (port_r == {1'b0, cfg.port_address}) &&
                     (16'(slot) < len_r);

  // datagram size as seen at the last byte
  assign size      = capture ? pos_r + PW'(1) : pos_r;
  assign need_size = 17'(art_pkg::MIN_DMX) + {1'b0, len_nxt};

  always_comb begin
    if (size < PW'(art_pkg::MIN_ANY) || !id_ok_nxt) begin
      kind = art_pkg::KIND_MALFORMED;
    end else if (opcode_nxt == art_pkg::OP_POLL) begin
      if (size < PW'(art_pkg::MIN_POLL) || version_nxt < cfg.min_version) begin
        kind = art_pkg::KIND_MALFORMED;
      end else begin
        kind = art_pkg::KIND_POLL;
      end
    end else if (opcode_nxt == art_pkg::OP_DMX) begin
      if (size < PW'(art_pkg::MIN_DMX) || !hdr_good_fin || 17'(size) < need_size) begin
        kind = art_pkg::KIND_MALFORMED;
      end else if (port_nxt != {1'b0, cfg.port_address}) begin
        kind = art_pkg::KIND_IGNORED;
      end else begin
        kind = art_pkg::KIND_DONE;
      end
    end else begin
      kind = art_pkg::KIND_IGNORED;
    end
  end

  assign mal_nxt = (kind == art_pkg::KIND_MALFORMED) ? mal_r + 32'd1 : mal_r;
  assign frm_nxt = (kind == art_pkg::KIND_DONE) ? frm_r + 32'd1 : frm_r;

  always_comb begin
    res_slot.kind            = art_pkg::KIND_SLOT;
    res_slot.slot_index      = slot[8:0];
    res_slot.slot_value      = data_byte;
    res_slot.frame_sequence  = seq_r;
    res_slot.physical_port   = phys_r;
    res_slot.frame_length    = len_r[9:0];
    res_slot.malformed_total = mal_r;
    res_slot.frame_total     = frm_r;
    res_slot.last_of_run     = !end_of_datagram;

    res_fin.kind            = kind;
    res_fin.slot_index      = '0;
    res_fin.slot_value      = '0;
    res_fin.frame_sequence  = (kind == art_pkg::KIND_DONE) ? seq_nxt : 8'd0;
    res_fin.physical_port   = (kind == art_pkg::KIND_DONE) ? phys_nxt : 8'd0;
    res_fin.frame_length    = (kind == art_pkg::KIND_DONE) ? len_nxt[9:0] : 10'd0;
    res_fin.malformed_total = mal_nxt;
    res_fin.frame_total     = frm_nxt;
    res_fin.last_of_run     = 1'b1;
  end

  // slot result goes first when a byte yields both
  always_comb begin
    res_a  = slot_emit ? res_slot : res_fin;
    res_b  = res_fin;
    push_n = '0;
    if (accept) begin
      push_n = {1'b0, slot_emit} + {1'b0, end_of_datagram};
    end
  end

  assign pos_nxt = size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      id_ok_r   <= 1'b1;
      opcode_r  <= '0;
      version_r <= '0;
      seq_r     <= '0;
      phys_r    <= '0;
      port_r    <= '0;
      len_r     <= '0;
      mal_r     <= '0;
      frm_r     <= '0;
    end else if (accept) begin
      if (end_of_datagram) begin
        // clear per-datagram state, update counters
        pos_r     <= '0;
        id_ok_r   <= 1'b1;
        opcode_r  <= '0;
        version_r <= '0;
        seq_r     <= '0;
        phys_r    <= '0;
        port_r    <= '0;
        len_r     <= '0;
        mal_r     <= mal_nxt;
        frm_r     <= frm_nxt;
      end else begin
        pos_r     <= pos_nxt;
        id_ok_r   <= id_ok_nxt;
        opcode_r  <= opcode_nxt;
        version_r <= version_nxt;
        seq_r     <= seq_nxt;
        phys_r    <= phys_nxt;
        port_r    <= port_nxt;
        len_r     <= len_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("byte position beyond datagram limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_datagram |=> pos_r == '0 && id_ok_r)
    else $error("datagram state not cleared after last byte");

  a_slot_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    slot_emit |-> pos_r >= POS_SLOT0 && len_r <= 16'(art_pkg::MAX_SLOTS))
    else $error("slot streamed without a good header");
`endif

endmodule

@@ src/art_outq.sv @@
// ----------------------------------------------------------------------------
// art_outq
// Small queue: takes up to two results a cycle, hands one out on out_ready.
// ----------------------------------------------------------------------------
module art_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  art_pkg::res_t push_a,
  input  art_pkg::res_t push_b,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output art_pkg::res_t head
);

  localparam int AW = art_pkg::OQ_AW;
  localparam int CW = art_pkg::OQ_CW;

  art_pkg::res_t mem [art_pkg::OQ_DEPTH];

  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_r];
  // room for two results regardless of the pop
  assign room      = cnt_r <= CW'(art_pkg::OQ_DEPTH - 2);
  assign cnt_nxt   = cnt_r + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_r + AW'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(push_n);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(art_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> cnt_r <= CW'(art_pkg::OQ_DEPTH - 2))
    else $error("double push without room");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd0 && !pop |=> $stable(cnt_r))
    else $error("queue count moved without traffic");
`endif

endmodule

@@ src/artnet_packet_parser.sv @@
// ----------------------------------------------------------------------------
// artnet_packet_parser
// Art-Net ArtDmx/ArtPoll receive parser, one payload byte per word.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_ready is high; a byte that carries a
//   slot and ends the datagram yields two results, which drain one per cycle
//   from a 4-entry queue while out_ready is high.
// Reset: synchronous rst_n clears parser state, counters and the result queue
//   and returns the registers to port address 0 and minimum version 14.
// ----------------------------------------------------------------------------
module artnet_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_datagram,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [8:0]  out_slot_index,
  output logic [7:0]  out_slot_value,
  output logic [7:0]  out_frame_sequence,
  output logic [7:0]  out_physical_port,
  output logic [9:0]  out_frame_length,
  output logic [31:0] out_malformed_total,
  output logic [31:0] out_frame_total,
  output logic        out_last_of_run,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  art_pkg::cfg_t cfg;
  art_pkg::res_t res_a, res_b, head;
  logic [1:0]    push_n;
  logic          accept;
  logic          room;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  art_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  art_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .end_of_datagram (in_end_of_datagram),
    .push_n          (push_n),
    .res_a           (res_a),
    .res_b           (res_b)
  );

  art_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind            = head.kind;
  assign out_slot_index      = head.slot_index;
  assign out_slot_value      = head.slot_value;
  assign out_frame_sequence  = head.frame_sequence;
  assign out_physical_port   = head.physical_port;
  assign out_frame_length    = head.frame_length;
  assign out_malformed_total = head.malformed_total;
  assign out_frame_total     = head.frame_total;
  assign out_last_of_run     = head.last_of_run;

endmodule

@@ tb/artnet_parser_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// artnet_parser_tb_pkg
// Expected-result tracking for the Art-Net packet parser bench: a byte-level
// model of the parser state and the registers, and the queue of results that
// the block still owes.
// ----------------------------------------------------------------------------
package artnet_parser_tb_pkg;

  import art_pkg::*;

  localparam bit [7:0] ART_ID [8] = '{8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00};

  localparam bit [2:0] ADDR_PORT    = {REG_PORT_ADDRESS, 2'b00};
  localparam bit [2:0] ADDR_MIN_VER = {REG_MIN_VERSION, 2'b00};

  class datagram_tracker;

    bit [14:0]   port_reg;
    bit [15:0]   min_ver_reg;

    int unsigned pos;
    bit          id_match;
    bit [15:0]   opcode;
    bit [15:0]   version;
    bit [7:0]    seq_byte;
    bit [7:0]    phys_byte;
    bit [15:0]   port;
    bit [15:0]   length;
    bit [31:0]   malformed_cnt;
    bit [31:0]   frame_cnt;

    res_t        pending_results[$];
    int          mismatches;

    function new();
      port_reg      = '0;
      min_ver_reg   = MIN_VER_RESET;
      malformed_cnt = '0;
      frame_cnt     = '0;
      mismatches    = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      pos       = 0;
      id_match  = 1'b1;
      opcode    = '0;
      version   = '0;
      seq_byte  = '0;
      phys_byte = '0;
      port      = '0;
      length    = '0;
    endfunction

    function bit header_good();
      return version >= min_ver_reg && length >= MIN_LEN && length <= MAX_SLOTS &&
             !length[0] && port <= PORT_LIMIT;
    endfunction

    function res_t make_result(bit [2:0] kind, bit [8:0] idx, bit [7:0] val,
                               bit with_frame, bit last);
      res_t r;
      r = '0;
      r.kind       = kind;
      r.slot_index = idx;
      r.slot_value = val;
      if (with_frame) begin
        r.frame_sequence = seq_byte;
        r.physical_port  = phys_byte;
        r.frame_length   = length[9:0];
      end
      r.malformed_total = malformed_cnt;
      r.frame_total     = frame_cnt;
      r.last_of_run     = last;
      return r;
    endfunction

    // advance the parser by one accepted word and queue what it causes
    function void take_byte(bit [7:0] b, bit eod);
      int unsigned slot;
      bit [2:0]    kind;
      if (pos < MAX_DATAGRAM) begin
        if (pos < 8) begin
          if (b != ART_ID[pos]) id_match = 1'b0;
        end else begin
          case (pos)
            POS_OPCODE_LO:  opcode = {8'h00, b};
            POS_OPCODE_HI:  opcode[15:8] = b;
            POS_VERSION_HI: version = {b, 8'h00};
            POS_VERSION_LO: version[7:0] = b;
            POS_SEQUENCE:   seq_byte = b;
            POS_PHYSICAL:   phys_byte = b;
            POS_PORT_LO:    port = {8'h00, b};
            POS_PORT_HI:    port[15:8] = b;
            POS_LENGTH_HI:  length = {b, 8'h00};
            POS_LENGTH_LO:  length[7:0] = b;
            default: begin
              slot = pos - MIN_DMX;
              if (id_match && opcode == OP_DMX && header_good() &&
                  port == {1'b0, port_reg} && slot < length)
                pending_results.push_back(make_result(KIND_SLOT, slot[8:0], b, 1'b1, !eod));
            end
          endcase
        end
        pos++;
      end
      if (eod) begin
        if (pos < MIN_ANY || !id_match) begin
          kind = KIND_MALFORMED;
        end else if (opcode == OP_POLL) begin
          kind = (pos < MIN_POLL || version < min_ver_reg) ? KIND_MALFORMED : KIND_POLL;
        end else if (opcode == OP_DMX) begin
          if (pos < MIN_DMX || !header_good() || pos < MIN_DMX + length)
            kind = KIND_MALFORMED;
          else if (port != {1'b0, port_reg})
            kind = KIND_IGNORED;
          else
            kind = KIND_DONE;
        end else begin
          kind = KIND_IGNORED;
        end
        if (kind == KIND_MALFORMED) malformed_cnt++;
        if (kind == KIND_DONE) frame_cnt++;
        pending_results.push_back(make_result(kind, '0, '0, kind == KIND_DONE, 1'b1));
        clear_datagram();
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result kind %0d with none expected", $time, got.kind);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("slot_index", want.slot_index, got.slot_index);
      compare("slot_value", want.slot_value, got.slot_value);
      compare("frame_sequence", want.frame_sequence, got.frame_sequence);
      compare("physical_port", want.physical_port, got.physical_port);
      compare("frame_length", want.frame_length, got.frame_length);
      compare("malformed_total", want.malformed_total, got.malformed_total);
      compare("frame_total", want.frame_total, got.frame_total);
      compare("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function void write_reg(bit [2:0] addr, bit [31:0] data);
      if (addr == ADDR_PORT)
        port_reg = data[14:0];
      else if (addr == ADDR_MIN_VER)
        min_ver_reg = data[15:0];
    endfunction

    function void match_reg(bit [2:0] addr, logic [31:0] got);
      compare("prdata", (addr == ADDR_PORT) ? {17'b0, port_reg} : {16'b0, min_ver_reg}, got);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

  endclass

endpackage

@@ tb/tb_artnet_packet_parser.sv @@
// ----------------------------------------------------------------------------
// tb_artnet_packet_parser
// Drives Art-Net datagrams byte by byte into the parser: directed header,
// size and ID corner cases, then random well-formed and broken datagrams
// under several register settings, with random stalls on both channels.
// Every result is checked field by field against the tracked expectation.
// ----------------------------------------------------------------------------
module tb_artnet_packet_parser;

  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;
  import artnet_parser_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte       = '0;
  logic        in_end_of_datagram = 1'b0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [2:0]  out_kind;
  logic [8:0]  out_slot_index;
  logic [7:0]  out_slot_value;
  logic [7:0]  out_frame_sequence;
  logic [7:0]  out_physical_port;
  logic [9:0]  out_frame_length;
  logic [31:0] out_malformed_total;
  logic [31:0] out_frame_total;
  logic        out_last_of_run;
  logic        psel               = 1'b0;
  logic        penable            = 1'b0;
  logic        pwrite             = 1'b0;
  logic [2:0]  paddr              = '0;
  logic [31:0] pwdata             = '0;
  logic [31:0] prdata;
  logic        pready;

  res_t            out_word;
  datagram_tracker book;
  bit [7:0]        dgram[$];
  bit              calm;
  int              phase_bytes;

  artnet_packet_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_end_of_datagram  (in_end_of_datagram),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_slot_index      (out_slot_index),
    .out_slot_value      (out_slot_value),
    .out_frame_sequence  (out_frame_sequence),
    .out_physical_port   (out_physical_port),
    .out_frame_length    (out_frame_length),
    .out_malformed_total (out_malformed_total),
    .out_frame_total     (out_frame_total),
    .out_last_of_run     (out_last_of_run),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  assign out_word = '{kind: out_kind, slot_index: out_slot_index,
                      slot_value: out_slot_value, frame_sequence: out_frame_sequence,
                      physical_port: out_physical_port, frame_length: out_frame_length,
                      malformed_total: out_malformed_total, frame_total: out_frame_total,
                      last_of_run: out_last_of_run};

  initial begin
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) book.take_byte(in_data_byte, in_end_of_datagram);
      if (out_valid && out_ready) book.match_result(out_word);
      if (psel && penable && pready) begin
        if (pwrite)
          book.write_reg(paddr, pwdata);
        else
          book.match_reg(paddr, prdata);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input bit [7:0] b, input bit eod);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           = 1'b1;
    in_data_byte       = b;
    in_end_of_datagram = eod;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_dg();
    calm = ($urandom_range(0, 3) == 0);
    phase_bytes += dgram.size();
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // drop valid, drain every owed result, then let the block settle
  task automatic finish_phase();
    @(negedge clk);
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // write, then read back through the same port
  task automatic cfg_write(input bit [2:0] addr, input bit [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ------------------------------------------------------- datagram builders

  function automatic void begin_dg(bit [15:0] op, bit [15:0] ver);
    dgram.delete();
    foreach (ART_ID[i]) dgram.push_back(ART_ID[i]);
    dgram.push_back(op[7:0]);
    dgram.push_back(op[15:8]);
    dgram.push_back(ver[15:8]);
    dgram.push_back(ver[7:0]);
  endfunction

  function automatic void add_bytes(int n);
    repeat (n) dgram.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void cut_to(int n);
    while (dgram.size() > n) void'(dgram.pop_back());
  endfunction

  function automatic void build_dmx(bit [15:0] ver, bit [15:0] port, bit [15:0] len,
                                    int nslots);
    begin_dg(OP_DMX, ver);
    add_bytes(2);
    dgram.push_back(port[7:0]);
    dgram.push_back(port[15:8]);
    dgram.push_back(len[15:8]);
    dgram.push_back(len[7:0]);
    add_bytes(nslots);
  endfunction

  function automatic void build_poll(bit [15:0] ver, int extra);
    begin_dg(OP_POLL, ver);
    add_bytes(2 + extra);
  endfunction

  function automatic void random_dg();
    bit [15:0] ver;
    bit [15:0] len;
    bit [15:0] port;
    bit [15:0] op;
    bit [7:0]  flip;
    int        nslots;
    int        r;
    int        fault;
    port = {1'b0, book.port_reg};
    ver  = 16'($urandom_range(16'hFFFF, book.min_ver_reg));
    if ($urandom_range(0, 29) == 0)
      len = 16'(2 * $urandom_range(17, 40));
    else
      len = 16'(2 * $urandom_range(1, 16));
    nslots = len;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      build_dmx(ver, port, len, nslots);
      if ($urandom_range(0, 2) == 0) add_bytes($urandom_range(1, 6));
    end else if (r < 55) begin
      build_poll(ver, $urandom_range(0, 6));
    end else if (r < 72) begin
      fault = $urandom_range(0, 7);
      case (fault)
        0: begin
          if (book.min_ver_reg != 0)
            ver = 16'($urandom_range(book.min_ver_reg - 1, 0));
          else
            port ^= 16'($urandom_range(1, 16'h7FFF));
        end
        1: len = len | 16'd1;
        2: len = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(16'hFFFF, 514));
        3: port = port | 16'h8000;
        4: nslots = $urandom_range(0, len - 1);
        5: port ^= 16'($urandom_range(1, 16'h7FFF));
        default: ;
      endcase
      build_dmx(ver, port, len, nslots);
      if (fault == 6) cut_to($urandom_range(10, 17));
      if (fault == 7) begin
        build_poll(ver, 0);
        cut_to($urandom_range(10, 13));
      end
    end else if (r < 82) begin
      dgram.delete();
      add_bytes($urandom_range(1, 24));
    end else if (r < 92) begin
      if ($urandom_range(0, 1))
        build_dmx(ver, port, len, nslots);
      else
        build_poll(ver, 0);
      flip = 8'h01 << $urandom_range(0, 7);
      dgram[$urandom_range(0, 7)] ^= flip;
    end else begin
      do op = 16'($urandom_range(0, 65535)); while (op == OP_POLL || op == OP_DMX);
      begin_dg(op, ver);
      add_bytes($urandom_range(0, 10));
    end
  endfunction

  // --------------------------------------------------------------- sequences

  task automatic run_directed();
    // smallest frame, extreme header bytes; last slot also ends the datagram
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd2, 2);
    dgram[12] = 8'hFF;
    dgram[13] = 8'hFF;
    dgram[18] = 8'h00;
    dgram[19] = 8'hFF;
    send_dg();
    // trailing bytes after the declared slots
    build_dmx(16'hFFFF, 16'h0000, 16'd4, 4);
    dgram[12] = 8'h00;
    dgram[13] = 8'h00;
    add_bytes(3);
    send_dg();
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd0, 0);
    add_bytes(2);
    send_dg();
    // slot count just above the limit
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd514, 0);
    send_dg();
    build_dmx(MIN_VER_RESET, 16'h8000, 16'd2, 2);
    send_dg();
    // truncated frame: slots stream, then the datagram ends malformed
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd8, 4);
    send_dg();
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd2, 0);
    cut_to(15);
    send_dg();
    build_poll(MIN_VER_RESET, 0);
    send_dg();
    build_poll(MIN_VER_RESET, 0);
    cut_to(13);
    send_dg();
    build_poll(MIN_VER_RESET, 0);
    cut_to(1);
    send_dg();
    build_poll(MIN_VER_RESET, 0);
    cut_to(9);
    send_dg();
    build_dmx(MIN_VER_RESET, 16'h0000, 16'd2, 2);
    cut_to(10);
    send_dg();
    // opcode with its bytes swapped is unknown
    begin_dg(16'h0050, MIN_VER_RESET);
    send_dg();
    // bad zero terminator of the ID
    build_poll(MIN_VER_RESET, 0);
    dgram[7] ^= 8'h01 << $urandom_range(0, 7);
    send_dg();
  endtask

  task automatic run_random(int budget);
    bit [14:0] port;
    bit [15:0] minv;
    case ($urandom_range(0, 3))
      0:       port = '0;
      1:       port = 15'h7FFF;
      default: port = 15'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(0, 3))
      0:       minv = '0;
      1:       minv = 16'hFFFF;
      2:       minv = MIN_VER_RESET;
      default: minv = 16'($urandom_range(0, 65535));
    endcase
    cfg_write(ADDR_PORT, {17'b0, port});
    cfg_write(ADDR_MIN_VER, {16'b0, minv});
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      random_dg();
      send_dg();
    end
    finish_phase();
  endtask

  initial begin : stimulus
    book = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    finish_phase();

    cfg_write(ADDR_PORT, 32'h0000_7FFF);
    cfg_write(ADDR_MIN_VER, 32'h0000_0000);
    build_dmx(16'h0000, 16'h7FFF, 16'd2, 2);
    send_dg();
    build_poll(16'h0000, 0);
    send_dg();
    build_dmx(16'h0000, 16'h0000, 16'd2, 2);
    send_dg();
    finish_phase();

    cfg_write(ADDR_PORT, 32'h0000_0000);
    cfg_write(ADDR_MIN_VER, 32'h0000_FFFF);
    build_poll(16'hFFFF, 0);
    send_dg();
    build_poll(16'hFFFE, 0);
    send_dg();
    finish_phase();

    repeat (3) run_random(30);

    if (book.mismatches == 0 && book.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ artnet_packet_parser.f @@
src/art_pkg.sv
src/art_cfg.sv
src/art_parse.sv
src/art_outq.sv
src/artnet_packet_parser.sv
tb/artnet_parser_tb_pkg.sv
tb/tb_artnet_packet_parser.sv
